/* design/mha_pkg.sv */
// mha_pkg: sizing constants, transaction structs, request and status codes,
// controller states and commands for the magazine handle allocator
// no dependencies
package mha_pkg;

   localparam int CORES         = 4;
   localparam int DEPTH_PER_MAG = 16;
   localparam int TOTAL_MAGS    = 64;
   localparam int HANDLE_BITS   = 32;

   localparam int PAIRS      = CORES * 2;
   localparam int SLOTS      = PAIRS * 2;
   localparam int STORE_SIZE = TOTAL_MAGS * DEPTH_PER_MAG;

   localparam int CORE_W   = (CORES > 1) ? $clog2(CORES) : 1;
   localparam int PAIR_W   = CORE_W + 1;
   localparam int SLOT_W   = CORE_W + 2;
   localparam int MAG_W    = $clog2(TOTAL_MAGS);
   localparam int LVL_W    = $clog2(TOTAL_MAGS + 1);
   localparam int FILL_W   = $clog2(DEPTH_PER_MAG + 1);
   localparam int ADDR_W   = $clog2(STORE_SIZE);
   localparam int LEVEL_FIELD_W = 7;

   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_FREE   = 2'd1;
   localparam logic [1:0] REQ_REMOTE = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_NO_MAG  = 2'd2,
      STATUS_REFUSED = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [1:0]             core_index;
      logic                   irq_context;
      logic [HANDLE_BITS-1:0] handle_in;
   } req_item_type;

   typedef struct packed {
      logic [HANDLE_BITS-1:0]   handle_out;
      logic                     granted;
      status_type               status;
      logic [LEVEL_FIELD_W-1:0] full_level;
      logic [LEVEL_FIELD_W-1:0] empty_level;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_REFILL_WAIT, ST_POP, ST_TRADE, ST_TRADE_WAIT, ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_LOAD, CMD_REFILL_ISSUE, CMD_REFILL_DONE, CMD_POP,
      CMD_FREE, CMD_TRADE, CMD_TRADE_DONE, CMD_FINISH
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    req_ready;
   } ctrl_out_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       refill_go;
      logic       trade_go;
      logic       trade_empty;
      logic       rsp_busy;
   } dp_status_type;

   // core_index modulo CORES by repeated subtraction (value is only 2 bits)
   function automatic logic [CORE_W-1:0] reduce_core(input logic [1:0] c);
      logic [4:0] v;
      v = {3'b000, c};
      for (int i = 0; i < 3; i++) begin
         if (int'(v) >= CORES) v = v - 5'(CORES);
      end
      return CORE_W'(v);
   endfunction

endpackage

/* design/mha_ram.sv */
// mha_ram: generic single write port, single read port RAM, registered read
// no dependencies
module mha_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/mha_ctrl.sv */
// mha_ctrl: sequencing state machine of the allocator
// depends on mha_pkg
module mha_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  mha_pkg::dp_status_type dp_status,
   output mha_pkg::ctrl_out_type  ctrl_out
);

   mha_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= mha_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mha_pkg::ST_IDLE: begin
            if (req_valid) state_in = mha_pkg::ST_DECODE;
         end
         mha_pkg::ST_DECODE: begin
            priority case (dp_status.kind)
               mha_pkg::REQ_ALLOC:
                  state_in = dp_status.refill_go ? mha_pkg::ST_REFILL_WAIT : mha_pkg::ST_POP;
               mha_pkg::REQ_REMOTE: state_in = mha_pkg::ST_POP;
               mha_pkg::REQ_FREE:
                  state_in = dp_status.trade_go ? mha_pkg::ST_TRADE : mha_pkg::ST_FINISH;
               default: state_in = mha_pkg::ST_FINISH;
            endcase
         end
         mha_pkg::ST_REFILL_WAIT: state_in = mha_pkg::ST_POP;
         mha_pkg::ST_POP:         state_in = mha_pkg::ST_FINISH;
         mha_pkg::ST_TRADE:
            state_in = dp_status.trade_empty ? mha_pkg::ST_TRADE_WAIT : mha_pkg::ST_FINISH;
         mha_pkg::ST_TRADE_WAIT:  state_in = mha_pkg::ST_FINISH;
         mha_pkg::ST_FINISH: begin
            if (!dp_status.rsp_busy) state_in = mha_pkg::ST_IDLE;
         end
         default: state_in = mha_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl_out.cmd       = mha_pkg::CMD_NONE;
      ctrl_out.req_ready = 1'b0;
      unique case (state_ff)
         mha_pkg::ST_IDLE: begin
            ctrl_out.req_ready = 1'b1;
            if (req_valid) ctrl_out.cmd = mha_pkg::CMD_LOAD;
         end
         mha_pkg::ST_DECODE: begin
            if (dp_status.kind == mha_pkg::REQ_ALLOC && dp_status.refill_go)
               ctrl_out.cmd = mha_pkg::CMD_REFILL_ISSUE;
            else if (dp_status.kind == mha_pkg::REQ_FREE)
               ctrl_out.cmd = mha_pkg::CMD_FREE;
         end
         mha_pkg::ST_REFILL_WAIT: ctrl_out.cmd = mha_pkg::CMD_REFILL_DONE;
         mha_pkg::ST_POP:         ctrl_out.cmd = mha_pkg::CMD_POP;
         mha_pkg::ST_TRADE:       ctrl_out.cmd = mha_pkg::CMD_TRADE;
         mha_pkg::ST_TRADE_WAIT:  ctrl_out.cmd = mha_pkg::CMD_TRADE_DONE;
         mha_pkg::ST_FINISH: begin
            if (!dp_status.rsp_busy) ctrl_out.cmd = mha_pkg::CMD_FINISH;
         end
         default: ctrl_out.cmd = mha_pkg::CMD_NONE;
      endcase
   end

endmodule

/* design/mha_datapath.sv */
// mha_datapath: magazine pair registers, depot counters, handle store and
// depot stack RAMs, result register
// depends on mha_pkg and mha_ram
module mha_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  mha_pkg::ctrl_out_type  ctrl_out,
   input  mha_pkg::req_item_type  req_item,
   output mha_pkg::dp_status_type dp_status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mha_pkg::rsp_item_type  rsp_item
);

   localparam int SW = mha_pkg::SLOT_W;
   localparam int FW = mha_pkg::FILL_W;
   localparam int MW = mha_pkg::MAG_W;
   localparam int LW = mha_pkg::LVL_W;
   localparam int AW = mha_pkg::ADDR_W;
   localparam int HW = mha_pkg::HANDLE_BITS;
   localparam logic [FW-1:0] FULL_FILL = FW'(mha_pkg::DEPTH_PER_MAG);
   localparam logic [LW-1:0] MAG_LIMIT = LW'(mha_pkg::TOTAL_MAGS);

   logic [MW-1:0] id_ff   [mha_pkg::SLOTS];
   logic [MW-1:0] id_in   [mha_pkg::SLOTS];
   logic [FW-1:0] fill_ff [mha_pkg::SLOTS];
   logic [FW-1:0] fill_in [mha_pkg::SLOTS];
   logic [LW-1:0] full_depth_ff, full_depth_in;
   logic [LW-1:0] empty_depth_ff, empty_depth_in;
   logic [LW-1:0] next_fresh_ff, next_fresh_in;
   logic [SW-1:0] slot_ff, slot_in;

   logic [1:0]                 kind_ff;
   logic [mha_pkg::CORE_W-1:0] core_ff;
   logic [mha_pkg::PAIR_W-1:0] pair_ff;
   logic [HW-1:0]              hin_ff;
   logic                       granted_ff, granted_in;
   mha_pkg::status_type        status_ff, status_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   mha_pkg::rsp_item_type      rsp_ff;

   logic          store_we, store_re;
   logic [AW-1:0] store_waddr, store_raddr;
   logic [HW-1:0] store_rdata;
   logic          full_we, full_re, empty_we, empty_re;
   logic [MW-1:0] full_waddr, full_raddr, empty_waddr, empty_raddr;
   logic [MW-1:0] full_wdata, empty_wdata, full_rdata, empty_rdata;

   logic [SW-1:0] s0, s1, pop_s0, pop_s1, free_s, trade_s;
   logic          free_ok;
   logic [FW:0]   pair_sum;
   logic [FW-1:0] pop_fill;

   function automatic logic [AW-1:0] store_addr(input logic [MW-1:0] id,
                                                input logic [FW-1:0] pos);
      return AW'(id) * AW'(mha_pkg::DEPTH_PER_MAG) + AW'(pos);
   endfunction

   mha_ram #(.WIDTH(HW), .DEPTH(mha_pkg::STORE_SIZE)) u_store (
      .clock(clock), .wr_en(store_we), .wr_addr(store_waddr), .wr_data(hin_ff),
      .rd_en(store_re), .rd_addr(store_raddr), .rd_data(store_rdata)
   );
   mha_ram #(.WIDTH(MW), .DEPTH(mha_pkg::TOTAL_MAGS)) u_full_stack (
      .clock(clock), .wr_en(full_we), .wr_addr(full_waddr), .wr_data(full_wdata),
      .rd_en(full_re), .rd_addr(full_raddr), .rd_data(full_rdata)
   );
   mha_ram #(.WIDTH(MW), .DEPTH(mha_pkg::TOTAL_MAGS)) u_empty_stack (
      .clock(clock), .wr_en(empty_we), .wr_addr(empty_waddr), .wr_data(empty_wdata),
      .rd_en(empty_re), .rd_addr(empty_raddr), .rd_data(empty_rdata)
   );

   assign s0       = {pair_ff, 1'b0};
   assign s1       = {pair_ff, 1'b1};
   assign pair_sum = {1'b0, fill_ff[s0]} + {1'b0, fill_ff[s1]};

   // remote allocation falls over to the interrupt pair when the task pair is dry
   always_comb begin
      pop_s0 = s0;
      pop_s1 = s1;
      if (kind_ff == mha_pkg::REQ_REMOTE) begin
         pop_s0 = {core_ff, 2'b00};
         pop_s1 = {core_ff, 2'b01};
         if (fill_ff[{core_ff, 2'b00}] == '0 && fill_ff[{core_ff, 2'b01}] == '0) begin
            pop_s0 = {core_ff, 2'b10};
            pop_s1 = {core_ff, 2'b11};
         end
      end
   end
   assign pop_fill = fill_ff[pop_s0] - 1'b1;

   always_comb begin
      free_ok = 1'b1;
      free_s  = s0;
      if (fill_ff[s0] < FULL_FILL)      free_s  = s0;
      else if (fill_ff[s1] < FULL_FILL) free_s  = s1;
      else                              free_ok = 1'b0;
   end
   assign trade_s = (fill_ff[s1] == FULL_FILL) ? s1 : s0;

   assign dp_status.kind        = kind_ff;
   assign dp_status.refill_go   = pair_sum == '0 && full_depth_ff != '0 &&
                                  empty_depth_ff < MAG_LIMIT;
   assign dp_status.trade_go    = free_ok &&
                                  (pair_sum + 1'b1) == (FW + 1)'(2 * mha_pkg::DEPTH_PER_MAG);
   assign dp_status.trade_empty = full_depth_ff < MAG_LIMIT && empty_depth_ff != '0;
   assign dp_status.rsp_busy    = rsp_valid_ff && !rsp_ready;

   always_comb begin
      id_in          = id_ff;
      fill_in        = fill_ff;
      full_depth_in  = full_depth_ff;
      empty_depth_in = empty_depth_ff;
      next_fresh_in  = next_fresh_ff;
      slot_in        = slot_ff;
      granted_in     = granted_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      store_we    = 1'b0;
      store_re    = 1'b0;
      store_waddr = store_addr(id_ff[free_s], fill_ff[free_s]);
      store_raddr = store_addr(id_ff[pop_s0], pop_fill);
      full_we     = 1'b0;
      full_re     = 1'b0;
      full_waddr  = MW'(full_depth_ff);
      full_raddr  = MW'(full_depth_ff - 1'b1);
      full_wdata  = id_ff[trade_s];
      empty_we    = 1'b0;
      empty_re    = 1'b0;
      empty_waddr = MW'(empty_depth_ff);
      empty_raddr = MW'(empty_depth_ff - 1'b1);
      empty_wdata = id_ff[s0];

      unique case (ctrl_out.cmd)
         mha_pkg::CMD_LOAD: begin
            granted_in = 1'b0;
            status_in  = mha_pkg::STATUS_OK;
         end
         mha_pkg::CMD_REFILL_ISSUE: begin
            // empty slot 0 goes to the depot, top full magazine comes back
            full_re        = 1'b1;
            empty_we       = 1'b1;
            full_depth_in  = full_depth_ff - 1'b1;
            empty_depth_in = empty_depth_ff + 1'b1;
            slot_in        = s0;
         end
         mha_pkg::CMD_REFILL_DONE: begin
            id_in[slot_ff]   = full_rdata;
            fill_in[slot_ff] = FULL_FILL;
         end
         mha_pkg::CMD_POP: begin
            if (fill_ff[pop_s0] == '0) begin
               status_in = mha_pkg::STATUS_EMPTY;
            end else begin
               store_re   = 1'b1;
               granted_in = 1'b1;
               if (pop_fill == '0) begin
                  id_in[pop_s0]   = id_ff[pop_s1];
                  id_in[pop_s1]   = id_ff[pop_s0];
                  fill_in[pop_s0] = fill_ff[pop_s1];
                  fill_in[pop_s1] = '0;
               end else begin
                  fill_in[pop_s0] = pop_fill;
               end
            end
         end
         mha_pkg::CMD_FREE: begin
            if (!free_ok) begin
               status_in = mha_pkg::STATUS_REFUSED;
            end else begin
               store_we        = 1'b1;
               fill_in[free_s] = fill_ff[free_s] + 1'b1;
            end
         end
         mha_pkg::CMD_TRADE: begin
            slot_in = trade_s;
            if (full_depth_ff >= MAG_LIMIT) begin
               status_in = mha_pkg::STATUS_NO_MAG;
            end else if (empty_depth_ff != '0) begin
               empty_re       = 1'b1;
               full_we        = 1'b1;
               full_depth_in  = full_depth_ff + 1'b1;
               empty_depth_in = empty_depth_ff - 1'b1;
            end else if (next_fresh_ff < MAG_LIMIT) begin
               full_we          = 1'b1;
               full_depth_in    = full_depth_ff + 1'b1;
               id_in[trade_s]   = MW'(next_fresh_ff);
               fill_in[trade_s] = '0;
               next_fresh_in    = next_fresh_ff + 1'b1;
            end else begin
               status_in = mha_pkg::STATUS_NO_MAG;
            end
         end
         mha_pkg::CMD_TRADE_DONE: begin
            id_in[slot_ff]   = empty_rdata;
            fill_in[slot_ff] = '0;
         end
         mha_pkg::CMD_FINISH: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mha_pkg::SLOTS; i++) begin
            id_ff[i]   <= MW'(i);
            fill_ff[i] <= '0;
         end
         full_depth_ff  <= '0;
         empty_depth_ff <= '0;
         next_fresh_ff  <= LW'(mha_pkg::SLOTS);
         rsp_valid_ff   <= 1'b0;
      end else begin
         id_ff          <= id_in;
         fill_ff        <= fill_in;
         full_depth_ff  <= full_depth_in;
         empty_depth_ff <= empty_depth_in;
         next_fresh_ff  <= next_fresh_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      granted_ff <= granted_in;
      status_ff  <= status_in;
      if (ctrl_out.cmd == mha_pkg::CMD_LOAD) begin
         kind_ff <= req_item.req_type;
         core_ff <= mha_pkg::reduce_core(req_item.core_index);
         pair_ff <= {mha_pkg::reduce_core(req_item.core_index), req_item.irq_context};
         hin_ff  <= req_item.handle_in;
      end
      if (ctrl_out.cmd == mha_pkg::CMD_FINISH) begin
         rsp_ff.handle_out  <= granted_ff ? store_rdata : '0;
         rsp_ff.granted     <= granted_ff;
         rsp_ff.status      <= status_ff;
         rsp_ff.full_level  <= mha_pkg::LEVEL_FIELD_W'(full_depth_ff);
         rsp_ff.empty_level <= mha_pkg::LEVEL_FIELD_W'(empty_depth_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* design/magazine_handle_allocator_unit.sv */
// magazine_handle_allocator_unit: top level of the magazine handle allocator
// depends on mha_pkg, mha_ctrl, mha_datapath
//
// Usage: one request transaction on req_ (allocate, free or remote allocate)
// gives exactly one response transaction on rsp_ with the handle, grant flag,
// status and the depot full and empty levels after the request.
// Requests are handled one at a time. From acceptance to rsp_valid the
// controller passes ST_DECODE, the states below, then ST_FINISH:
//   free without magazine trade           none
//   free with trade from a fresh magazine ST_TRADE
//   free with trade from the empty depot  ST_TRADE, ST_TRADE_WAIT
//   allocation                            ST_POP; ST_REFILL_WAIT, ST_POP with a refill
// req_ready rises again in the cycle the response is presented; the handle
// store and depot stack RAM reads each have a registered output.
// The response register holds a finished transaction while the next request
// is taken; a stalled receiver only holds the block in its final step.
// Reset is synchronous: pairs get their initial magazines, fills and depot
// levels clear; the store and depot stacks need no clearing pass.
module magazine_handle_allocator_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mha_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mha_pkg::rsp_item_type rsp_item
);

   mha_pkg::ctrl_out_type  ctrl_out;
   mha_pkg::dp_status_type dp_status;

   mha_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .dp_status(dp_status), .ctrl_out(ctrl_out)
   );

   mha_datapath u_datapath (
      .clock(clock), .reset(reset), .ctrl_out(ctrl_out), .req_item(req_item),
      .dp_status(dp_status), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_item(rsp_item)
   );

   assign req_ready = ctrl_out.req_ready;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.granted |-> rsp_item.status == mha_pkg::STATUS_OK)
      else $error("granted response with error status");

   a_zero_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.granted |-> rsp_item.handle_out == '0)
      else $error("handle given without grant");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      ctrl_out.cmd == mha_pkg::CMD_FINISH |=> rsp_valid)
      else $error("finished transaction not presented");

endmodule
